// File: rtl/core/skl_pkg.sv
// Shared constants, opcode codes and register map of the sorted key list engine.
`default_nettype none
package skl_pkg;

	localparam int DEPTH_DEF    = 64;
	localparam int KEY_BITS_DEF = 32;

	localparam int KEY_IN_W = 32;
	localparam int FIELD_W  = 7;
	localparam int CFG_AW   = 3;
	localparam int CFG_DW   = 32;

	localparam logic [FIELD_W-1:0] MAX_ENTRIES_RST = 7'd64;

	typedef enum logic [0:0] {
		REG_MAX_ENTRIES = 1'b0
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_CNT_LO   = 3'd1,
		OP_CNT_HI   = 3'd2,
		OP_DROP_LO  = 3'd3,
		OP_DROP_HI  = 3'd4,
		OP_SEARCH   = 3'd5,
		OP_CNT_EQ   = 3'd6,
		OP_NOP      = 3'd7
	} op_t;

endpackage
`default_nettype wire

// File: rtl/core/skl_mem.sv
// Key store: simple dual-port synchronous memory with registered read data.
`default_nettype none
module skl_mem #(
	parameter int DEPTH    = skl_pkg::DEPTH_DEF,
	parameter int KEY_BITS = skl_pkg::KEY_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic signed [KEY_BITS-1:0]      rdata,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic signed [KEY_BITS-1:0] wdata
);

	logic [KEY_BITS-1:0] mem_q [DEPTH];
	logic [KEY_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = $signed(rdata_q);

endmodule
`default_nettype wire

// File: rtl/core/skl_seq.sv
// Sequencer: scans the key store for ranks, then shifts, inserts or trims the list.
`default_nettype none
module skl_seq #(
	parameter int DEPTH    = skl_pkg::DEPTH_DEF,
	parameter int KEY_BITS = skl_pkg::KEY_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [2:0]                            opcode,
	input  wire logic signed [skl_pkg::KEY_IN_W-1:0]   key,
	input  wire logic [skl_pkg::FIELD_W-1:0]           max_entries,
	output logic                                       done,
	output logic [skl_pkg::FIELD_W-1:0]                count,
	output logic                                       found,
	output logic                                       rejected,
	output logic [skl_pkg::FIELD_W-1:0]                entries,
	output logic                                       mem_re,
	output logic [$clog2(DEPTH)-1:0]                   mem_raddr,
	input  wire logic signed [KEY_BITS-1:0]            mem_rdata,
	output logic                                       mem_we,
	output logic [$clog2(DEPTH)-1:0]                   mem_waddr,
	output logic signed [KEY_BITS-1:0]                 mem_wdata
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int FW   = skl_pkg::FIELD_W;
	localparam int CAPW = (CW > FW) ? CW : FW;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_MOVE = 5'b00100,
		ST_PUT  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                     state_q;
	skl_pkg::op_t               op_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic [CW-1:0]              len_q;
	logic [CW-1:0]              below_q;
	logic [CW-1:0]              upto_q;
	logic [CW-1:0]              ridx_q;
	logic [CW-1:0]              mv_left_q;
	logic [AW-1:0]              src_q;
	logic                       up_q;
	logic                       rej_q;
	logic                       v_s1;
	logic [AW-1:0]              src_s1;
	logic                       done_q;
	logic [FW-1:0]              count_q;
	logic                       found_q;
	logic                       rejected_q;
	logic [FW-1:0]              entries_q;

	logic signed [63:0]         key_ext;
	logic signed [KEY_BITS-1:0] key_in;
	logic [CAPW-1:0]            cap;
	logic                       full;
	logic                       scan_re;
	logic                       mv_re;
	logic                       key_lt;
	logic                       key_le;
	logic [CW-1:0]              res_cnt;

	assign key_ext = 64'(key);
	assign key_in  = key_ext[KEY_BITS-1:0];

	assign cap  = (CAPW'(max_entries) > CAPW'(DEPTH)) ? CAPW'(DEPTH) : CAPW'(max_entries);
	assign full = CAPW'(len_q) >= cap;

	assign scan_re = (state_q == ST_SCAN) && (ridx_q < len_q);
	assign mv_re   = (state_q == ST_MOVE) && (mv_left_q != '0);
	assign mem_re  = scan_re | mv_re;
	assign mem_raddr = (state_q == ST_MOVE) ? src_q : ridx_q[AW-1:0];

	assign mem_we    = (state_q == ST_PUT) || ((state_q == ST_MOVE) && v_s1);
	assign mem_waddr = (state_q == ST_PUT) ? upto_q[AW-1:0] :
		(up_q ? src_s1 + AW'(1) : src_s1 - below_q[AW-1:0]);
	assign mem_wdata = (state_q == ST_PUT) ? key_q : mem_rdata;

	assign key_lt = mem_rdata < key_q;
	assign key_le = key_lt || (mem_rdata == key_q);

	always_comb begin
		case (op_q)
			skl_pkg::OP_CNT_LO: res_cnt = below_q;
			skl_pkg::OP_CNT_HI: res_cnt = len_q - upto_q;
			skl_pkg::OP_CNT_EQ: res_cnt = upto_q - below_q;
			default:            res_cnt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			v_s1       <= 1'b0;
			done_q     <= 1'b0;
			op_q       <= skl_pkg::OP_NOP;
			rej_q      <= 1'b0;
			below_q    <= '0;
			upto_q     <= '0;
			ridx_q     <= '0;
			mv_left_q  <= '0;
			src_q      <= '0;
			up_q       <= 1'b0;
		end else begin
			v_s1   <= mem_re;
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= skl_pkg::op_t'(opcode);
						ridx_q  <= '0;
						below_q <= '0;
						upto_q  <= '0;
						rej_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_re) begin
						ridx_q <= ridx_q + CW'(1);
					end
					if (v_s1) begin
						below_q <= below_q + CW'(key_lt);
						upto_q  <= upto_q + CW'(key_le);
					end
					if (!scan_re && !v_s1) begin
						case (op_q)
							skl_pkg::OP_INSERT: begin
								if (full) begin
									rej_q   <= 1'b1;
									state_q <= ST_FIN;
								end else if (len_q > upto_q) begin
									src_q     <= AW'(len_q - CW'(1));
									mv_left_q <= len_q - upto_q;
									up_q      <= 1'b1;
									state_q   <= ST_MOVE;
								end else begin
									state_q <= ST_PUT;
								end
							end
							skl_pkg::OP_DROP_LO: begin
								len_q <= len_q - below_q;
								if (below_q != '0 && len_q != below_q) begin
									src_q     <= below_q[AW-1:0];
									mv_left_q <= len_q - below_q;
									up_q      <= 1'b0;
									state_q   <= ST_MOVE;
								end else begin
									state_q <= ST_FIN;
								end
							end
							skl_pkg::OP_DROP_HI: begin
								len_q   <= upto_q;
								state_q <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_MOVE: begin
					if (mv_re) begin
						src_q     <= up_q ? src_q - AW'(1) : src_q + AW'(1);
						mv_left_q <= mv_left_q - CW'(1);
					end
					if (!mv_re && !v_s1) begin
						state_q <= (op_q == skl_pkg::OP_INSERT) ? ST_PUT : ST_FIN;
					end
				end
				ST_PUT: begin
					len_q   <= len_q + CW'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			key_q <= key_in;
		end
		src_s1 <= src_q;
		if (state_q == ST_FIN) begin
			count_q    <= FW'(res_cnt);
			found_q    <= (op_q == skl_pkg::OP_SEARCH) && (upto_q != below_q);
			rejected_q <= rej_q;
			entries_q  <= FW'(len_q);
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign count    = count_q;
	assign found    = found_q;
	assign rejected = rejected_q;
	assign entries  = entries_q;

endmodule
`default_nettype wire

// File: rtl/core/sorted_key_list_engine_core.sv
// Top level of the sorted key list engine: register port, sequencer and key store.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-----------------------------------
//  command   | start, busy               | opcode, key
//  result    | done (one-cycle strobe)   | count, found, rejected, entries
//  register  | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// One item at a time; busy is high from acceptance until the result strobe.
// An item first scans the held keys for its rank (one store read per
// held key), then an insert or a drop below shifts the list one key at a
// time through the single read port of the key store.
// Reset empties the list at once and sets max_entries to 64; no clearing pass.
// The result is shown for exactly one cycle and cannot be held off.
`default_nettype none
module sorted_key_list_engine_core #(
	parameter int DEPTH    = skl_pkg::DEPTH_DEF,
	parameter int KEY_BITS = skl_pkg::KEY_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [2:0]                          opcode,
	input  wire logic signed [skl_pkg::KEY_IN_W-1:0] key,
	output logic                                     done,
	output logic [skl_pkg::FIELD_W-1:0]              count,
	output logic                                     found,
	output logic                                     rejected,
	output logic [skl_pkg::FIELD_W-1:0]              entries,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [skl_pkg::CFG_AW-1:0]          paddr,
	input  wire logic [skl_pkg::CFG_DW-1:0]          pwdata,
	output logic [skl_pkg::CFG_DW-1:0]               prdata,
	output logic                                     pready
);

	localparam int AW = $clog2(DEPTH);

	logic [skl_pkg::FIELD_W-1:0] max_q;
	logic                        reg_hit;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic signed [KEY_BITS-1:0]  mem_rdata;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic signed [KEY_BITS-1:0]  mem_wdata;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[skl_pkg::CFG_AW-1] == skl_pkg::REG_MAX_ENTRIES);
	assign prdata  = reg_hit ? skl_pkg::CFG_DW'(max_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= skl_pkg::MAX_ENTRIES_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			max_q <= pwdata[skl_pkg::FIELD_W-1:0];
		end
	end

	skl_seq #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.key         (key),
		.max_entries (max_q),
		.done        (done),
		.count       (count),
		.found       (found),
		.rejected    (rejected),
		.entries     (entries),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata)
	);

	skl_mem #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the sorted key list engine: directed table, random phases, register.
`timescale 1ns / 100ps
module tb_top;
	import skl_pkg::*;

	typedef struct packed {
		logic [FIELD_W-1:0] count;
		logic               found;
		logic               rejected;
		logic [FIELD_W-1:0] entries;
	} reply_t;

	typedef struct packed {
		op_t                        op;
		logic signed [KEY_IN_W-1:0] k;
		logic                       typed;
		reply_t                     reply;
	} step_t;

	localparam int          CYCLE_LIMIT  = 600_000;
	localparam int          TAIL_CYCLES  = 2 * DEPTH_DEF + 16;
	localparam int          PHASES       = 9;
	localparam int          PHASE_ITEMS  = 75;
	localparam int          PLAN_ROWS    = 25;
	localparam logic [CFG_AW-1:0] ADDR_MAX_ENTRIES = {REG_MAX_ENTRIES, 2'b00};
	localparam logic [CFG_AW-1:0] ADDR_UNMAPPED    = 3'd4;
	localparam logic signed [KEY_IN_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KEY_IN_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	logic                       clk     = 1'b0;
	logic                       arst_n  = 1'b0;
	logic                       start   = 1'b0;
	logic [2:0]                 opcode  = '0;
	logic signed [KEY_IN_W-1:0] key     = '0;
	logic                       psel    = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite  = 1'b0;
	logic [CFG_AW-1:0]          paddr   = '0;
	logic [CFG_DW-1:0]          pwdata  = '0;
	logic                       busy;
	logic                       done;
	logic [FIELD_W-1:0]         count;
	logic                       found;
	logic                       rejected;
	logic [FIELD_W-1:0]         entries;
	logic [CFG_DW-1:0]          prdata;
	logic                       pready;

	logic signed [KEY_IN_W-1:0] held_keys [DEPTH_DEF];
	int                         held_len   = 0;
	logic [FIELD_W-1:0]         cap_reg    = MAX_ENTRIES_RST;
	reply_t                     replies_due [$];
	int                         mismatches = 0;
	int                         cycle_count = 0;
	bit                         gaps_on    = 1'b1;

	int unsigned phase_cap [PHASES] = '{64, 1, 0, 64, 5, 100, 127, 64, 2};
	int unsigned phase_ins [PHASES] = '{70, 60, 50, 90, 50, 80, 85, 40, 60};

	step_t plan [PLAN_ROWS] = '{
		'{OP_CNT_LO,  32'sd0,       1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}},
		'{OP_CNT_HI,  32'sd0,       1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}},
		'{OP_SEARCH,  KEY_MIN,      1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}},
		'{OP_CNT_EQ,  KEY_MAX,      1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}},
		'{OP_DROP_LO, 32'sd0,       1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}},
		'{OP_DROP_HI, 32'sd0,       1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}},
		'{OP_INSERT,  KEY_MAX,      1'b1, '{7'd0, 1'b0, 1'b0, 7'd1}},
		'{OP_INSERT,  KEY_MIN,      1'b1, '{7'd0, 1'b0, 1'b0, 7'd2}},
		'{OP_INSERT,  32'sd0,       1'b1, '{7'd0, 1'b0, 1'b0, 7'd3}},
		'{OP_INSERT,  32'sd0,       1'b1, '{7'd0, 1'b0, 1'b0, 7'd4}},
		'{OP_INSERT,  -32'sd1,      1'b1, '{7'd0, 1'b0, 1'b0, 7'd5}},
		'{OP_CNT_EQ,  32'sd0,       1'b0, '0},
		'{OP_CNT_LO,  32'sd0,       1'b0, '0},
		'{OP_CNT_HI,  32'sd0,       1'b0, '0},
		'{OP_SEARCH,  32'sd0,       1'b0, '0},
		'{OP_SEARCH,  32'sd5,       1'b0, '0},
		'{OP_NOP,     32'sh5A5A_A5A5, 1'b0, '0},
		'{OP_CNT_HI,  KEY_MIN,      1'b0, '0},
		'{OP_CNT_LO,  KEY_MAX,      1'b0, '0},
		'{OP_DROP_LO, 32'sd0,       1'b0, '0},
		'{OP_DROP_HI, 32'sd0,       1'b0, '0},
		'{OP_DROP_LO, KEY_MAX,      1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}},
		'{OP_INSERT,  32'sh5555_5555, 1'b1, '{7'd0, 1'b0, 1'b0, 7'd1}},
		'{OP_INSERT,  32'shAAAA_AAAA, 1'b1, '{7'd0, 1'b0, 1'b0, 7'd2}},
		'{OP_DROP_HI, KEY_MIN,      1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}}
	};

	sorted_key_list_engine_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.key      (key),
		.done     (done),
		.count    (count),
		.found    (found),
		.rejected (rejected),
		.entries  (entries),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic reply_t list_reply(input op_t op, input logic signed [KEY_IN_W-1:0] k);
		reply_t r;
		int     below;
		int     upto;
		int     cap;
		r     = '0;
		below = 0;
		upto  = 0;
		cap   = (cap_reg > DEPTH_DEF) ? DEPTH_DEF : int'(cap_reg);
		for (int i = 0; i < held_len; i++) begin
			if (held_keys[i] < k)
				below++;
			if (held_keys[i] <= k)
				upto++;
		end
		case (op)
			OP_INSERT: begin
				if (held_len >= cap) begin
					r.rejected = 1'b1;
				end else begin
					for (int i = held_len; i > upto; i--)
						held_keys[i] = held_keys[i-1];
					held_keys[upto] = k;
					held_len++;
				end
			end
			OP_CNT_LO: r.count = FIELD_W'(below);
			OP_CNT_HI: r.count = FIELD_W'(held_len - upto);
			OP_DROP_LO: begin
				for (int i = 0; i < held_len - below; i++)
					held_keys[i] = held_keys[i+below];
				held_len -= below;
			end
			OP_DROP_HI: held_len = upto;
			OP_SEARCH:  r.found = (upto > below);
			OP_CNT_EQ:  r.count = FIELD_W'(upto - below);
			default: ;
		endcase
		r.entries = FIELD_W'(held_len);
		return r;
	endfunction

	function automatic op_t pick_op(input int unsigned ins_pct);
		if ($urandom_range(0, 99) < ins_pct)
			return OP_INSERT;
		case ($urandom_range(0, 19))
			0, 1, 2, 3:     return OP_CNT_LO;
			4, 5, 6, 7:     return OP_CNT_HI;
			8, 9, 10, 11:   return OP_SEARCH;
			12, 13, 14, 15: return OP_CNT_EQ;
			16:             return OP_DROP_LO;
			17:             return OP_DROP_HI;
			default:        return OP_NOP;
		endcase
	endfunction

	function automatic logic signed [KEY_IN_W-1:0] pick_key();
		int unsigned r;
		int          pool;
		r    = $urandom_range(0, 99);
		pool = $urandom_range(0, 8);
		if (held_len > 0 && r < 30)
			return held_keys[$urandom_range(0, held_len - 1)];
		if (r < 60)
			return pool - 4;
		if (r < 70) begin
			case ($urandom_range(0, 3))
				0:       return KEY_MIN;
				1:       return KEY_MAX;
				2:       return '0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic report_bad(input string what, input reply_t want, input reply_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%0t %s: expected count=%0d found=%0b rejected=%0b entries=%0d, ",
				$realtime, what, want.count, want.found, want.rejected, want.entries);
			$display("got count=%0d found=%0b rejected=%0b entries=%0d",
				got.count, got.found, got.rejected, got.entries);
		end
	endtask

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		got = '{count, found, rejected, entries};
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				report_bad("result with no item pending", '0, got);
			end else begin
				want = replies_due.pop_front();
				if (got.count !== want.count || got.found !== want.found ||
				    got.rejected !== want.rejected || got.entries !== want.entries)
					report_bad("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic reg_access(input bit wr, input logic [CFG_AW-1:0] addr,
	                          input logic [CFG_DW-1:0] data, output logic [CFG_DW-1:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (wr && addr == ADDR_MAX_ENTRIES)
			cap_reg = data[FIELD_W-1:0];
		@(posedge clk);
	endtask

	task automatic check_cap();
		logic [CFG_DW-1:0] rd;
		reg_access(1'b0, ADDR_MAX_ENTRIES, '0, rd);
		if (rd !== CFG_DW'(cap_reg)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t max_entries readback: expected %0d, got %0h",
					$realtime, cap_reg, rd);
		end
	endtask

	task automatic issue(input op_t op, input logic signed [KEY_IN_W-1:0] k,
	                     input logic typed, input reply_t typed_reply);
		reply_t predicted;
		start  <= 1'b1;
		opcode <= op;
		key    <= k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = list_reply(op, k);
		replies_due.push_back(typed ? typed_reply : predicted);
	endtask

	task automatic maybe_pause();
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (replies_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	initial begin
		logic [CFG_DW-1:0] rd;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_cap();

		for (int i = 0; i < PLAN_ROWS; i++) begin
			issue(plan[i].op, plan[i].k, plan[i].typed, plan[i].reply);
			maybe_pause();
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			@(posedge clk);
			reg_access(1'b1, ADDR_MAX_ENTRIES,
				($urandom & ~CFG_DW'(32'h7F)) | CFG_DW'(phase_cap[p]), rd);
			if (p == 0)
				reg_access(1'b1, ADDR_UNMAPPED, $urandom, rd);
			check_cap();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 20 == 0)
					gaps_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
				issue(pick_op(phase_ins[p]), pick_key(), 1'b0, '0);
				if (p != PHASES - 1 && $urandom_range(0, 99) == 0)
					drain();
				else
					maybe_pause();
			end
		end

		drain();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (replies_due.size() != 0)
			mismatches++;
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
